### hdl/umdl_pkg.sv
`timescale 1ns / 1ps
package umdl_pkg;

	localparam int RX_DEPTH_DEF = 256;
	localparam int CMDQ_DEPTH   = 4;
	localparam int OUTQ_DEPTH   = 4;
	localparam int NUM_WORDS    = 18;

	localparam logic [11:0] WINDOW      = 12'h048;
	localparam logic [11:0] OFS_CR      = 12'h000;
	localparam logic [11:0] OFS_MR      = 12'h004;
	localparam logic [11:0] OFS_IER     = 12'h008;
	localparam logic [11:0] OFS_IDR     = 12'h00C;
	localparam logic [11:0] OFS_ISR     = 12'h014;
	localparam logic [11:0] OFS_BAUDGEN = 12'h018;
	localparam logic [11:0] OFS_RXTOUT  = 12'h01C;
	localparam logic [11:0] OFS_RXWM    = 12'h020;
	localparam logic [11:0] OFS_MODEMCR = 12'h024;
	localparam logic [11:0] OFS_MODEMSR = 12'h028;
	localparam logic [11:0] OFS_SR      = 12'h02C;
	localparam logic [11:0] OFS_FIFO    = 12'h030;
	localparam logic [11:0] OFS_BAUDDIV = 12'h034;
	localparam logic [11:0] OFS_FLOWDEL = 12'h038;
	localparam logic [11:0] OFS_TXWM    = 12'h044;

	typedef logic [4:0] rf_idx_t;

	localparam rf_idx_t IDX_CR  = 5'd0;
	localparam rf_idx_t IDX_IMR = 5'd4;
	localparam rf_idx_t IDX_ISR = 5'd5;

	localparam logic [31:0] CR_AUTO_CLEAR = 32'h0000_0043;
	localparam logic [31:0] BIT_RTRIG     = 32'h0000_0001;
	localparam logic [31:0] BIT_REMPTY    = 32'h0000_0002;
	localparam logic [31:0] BIT_TEMPTY    = 32'h0000_0008;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_RX    = 2'd2,
		MODE_ACK   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_RD_REG,
		OP_RD_SR,
		OP_RD_FIFO,
		OP_WR_IER,
		OP_WR_IDR,
		OP_WR_ISR,
		OP_WR_CR,
		OP_WR_REG,
		OP_WR_FIFO,
		OP_RX,
		OP_ACK
	} op_t;

	typedef struct packed {
		op_t         op;
		rf_idx_t     idx;
		logic [31:0] data;
		logic [31:0] mask;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        tx_valid;
		logic [7:0]  tx_char;
		logic        raise_irq;
	} res_t;

	function automatic logic [31:0] rf_reset_value(input int i);
		logic [31:0] v;
		case (i)
			0:       v = 32'h0000_0128;
			5:       v = 32'h0000_0208;
			6:       v = 32'h0000_028B;
			8:       v = 32'h0000_0020;
			13:      v = 32'h0000_000F;
			17:      v = 32'h0000_0020;
			default: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

### hdl/umdl_ram.sv
`timescale 1ns / 1ps
module umdl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/umdl_fifo.sv
`timescale 1ns / 1ps
module umdl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rdata   = slot_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

### hdl/umdl_front.sv
`timescale 1ns / 1ps
module umdl_front
	import umdl_pkg::*;
(
	input  logic [1:0]  mode,
	input  logic [11:0] offset,
	input  logic [31:0] write_data,
	input  logic [31:0] byte_mask,
	input  logic [7:0]  rx_char,
	output cmd_t        cmd
);

	logic in_window;

	assign in_window = (offset < WINDOW);

	always_comb begin
		cmd      = '0;
		cmd.op   = OP_NONE;
		cmd.idx  = offset[6:2];
		cmd.data = write_data;
		cmd.mask = byte_mask;
		unique case (mode_t'(mode))
			MODE_READ: begin
				if (!in_window) begin
					cmd.op = OP_NONE;
				end else if (offset == OFS_SR) begin
					cmd.op = OP_RD_SR;
				end else if (offset == OFS_FIFO) begin
					cmd.op = OP_RD_FIFO;
				end else begin
					cmd.op = OP_RD_REG;
				end
			end
			MODE_WRITE: begin
				unique case (offset) inside
					OFS_IER:  cmd.op = OP_WR_IER;
					OFS_IDR:  cmd.op = OP_WR_IDR;
					OFS_ISR:  cmd.op = OP_WR_ISR;
					OFS_CR:   cmd.op = OP_WR_CR;
					OFS_FIFO: cmd.op = OP_WR_FIFO;
					OFS_MR, OFS_BAUDGEN, OFS_RXTOUT, OFS_RXWM, OFS_MODEMCR,
					OFS_MODEMSR, OFS_BAUDDIV, OFS_FLOWDEL, OFS_TXWM:
						cmd.op = OP_WR_REG;
					default:  cmd.op = OP_NONE;
				endcase
			end
			MODE_RX: begin
				cmd.op   = OP_RX;
				cmd.data = {24'd0, rx_char};
			end
			MODE_ACK: begin
				cmd.op = OP_ACK;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

### hdl/umdl_back.sv
`timescale 1ns / 1ps
module umdl_back
	import umdl_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int OQ_DEPTH = OUTQ_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	input  logic                          cmd_empty,
	output logic                          cmd_pop,
	input  logic [$clog2(OQ_DEPTH+1)-1:0] oq_level,
	output logic                          res_push,
	output res_t                          res
);

	localparam int AW = $clog2(RX_DEPTH);
	localparam int CW = $clog2(RX_DEPTH + 1);
	localparam int LW = $clog2(OQ_DEPTH + 1);

	logic [31:0]   rf_q [NUM_WORDS];
	logic [31:0]   rf_d [NUM_WORDS];
	logic [AW-1:0] head_q;
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          pend_q;
	logic          pend_d;

	logic          s2_v;
	res_t          res_s2;
	logic          ram_sel_s2;
	res_t          res_d;
	logic          ram_sel_d;

	logic          fire;
	logic [CW:0]   tail_sum;
	logic [CW:0]   tail_w;
	logic [AW:0]   head_inc;
	logic [AW-1:0] head_next;
	logic          ram_we;
	logic [7:0]    ram_rdata;

	// keep one slot free in the result queue for every word in flight
	assign fire    = ~cmd_empty &
		(({1'b0, oq_level} + (LW+1)'(s2_v)) < (LW+1)'(OQ_DEPTH));
	assign cmd_pop = fire;

	assign tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail_w    = (tail_sum >= (CW+1)'(RX_DEPTH)) ? tail_sum - (CW+1)'(RX_DEPTH)
		: tail_sum;
	assign head_inc  = (AW+1)'(head_q) + 1'b1;
	assign head_next = (head_inc >= (AW+1)'(RX_DEPTH)) ? '0 : head_inc[AW-1:0];

	always_comb begin
		rf_d      = rf_q;
		head_d    = head_q;
		count_d   = count_q;
		pend_d    = pend_q;
		res_d     = '0;
		ram_sel_d = 1'b0;
		ram_we    = 1'b0;
		if (fire) begin
			unique case (cmd.op)
				OP_RD_REG: res_d.read_data = rf_q[cmd.idx];
				OP_RD_SR: begin
					res_d.read_data = BIT_TEMPTY | ((count_q == '0) ? BIT_REMPTY : '0);
				end
				OP_RD_FIFO: begin
					if (count_q != '0) begin
						ram_sel_d = 1'b1;
						head_d    = head_next;
						count_d   = count_q - 1'b1;
					end
					if (count_q == '0 || count_q == CW'(1)) begin
						rf_d[IDX_ISR] = rf_q[IDX_ISR] & ~BIT_RTRIG;
					end
				end
				OP_WR_IER: rf_d[IDX_IMR] = rf_q[IDX_IMR] | (cmd.data & cmd.mask);
				OP_WR_IDR: rf_d[IDX_IMR] = rf_q[IDX_IMR] & ~(cmd.data & cmd.mask);
				OP_WR_ISR: begin
					rf_d[IDX_ISR] = (rf_q[IDX_ISR] & ~(cmd.data & cmd.mask)) | BIT_TEMPTY;
				end
				OP_WR_CR: begin
					rf_d[IDX_CR] = ((rf_q[IDX_CR] & ~cmd.mask) | (cmd.data & cmd.mask))
						& ~CR_AUTO_CLEAR;
				end
				OP_WR_REG: begin
					rf_d[cmd.idx] = (rf_q[cmd.idx] & ~cmd.mask) | (cmd.data & cmd.mask);
				end
				OP_WR_FIFO: begin
					res_d.tx_valid  = 1'b1;
					res_d.tx_char   = cmd.data[7:0];
					res_d.raise_irq = ~pend_q;
					pend_d          = 1'b1;
				end
				OP_RX: begin
					// a full queue drops the character but still flags it
					if (count_q != CW'(RX_DEPTH)) begin
						ram_we  = 1'b1;
						count_d = count_q + 1'b1;
					end
					rf_d[IDX_ISR]   = rf_q[IDX_ISR] | BIT_RTRIG;
					res_d.raise_irq = ~pend_q;
					pend_d          = 1'b1;
				end
				OP_ACK: begin
					if ((rf_q[IDX_ISR] & rf_q[IDX_IMR]) != '0) begin
						res_d.raise_irq = 1'b1;
					end else begin
						pend_d = 1'b0;
					end
				end
				default: res_d = '0;
			endcase
		end
	end

	umdl_ram #(
		.WIDTH(8),
		.DEPTH(RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_w[AW-1:0]),
		.wdata (cmd.data[7:0]),
		.re    (fire),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				rf_q[i] <= rf_reset_value(i);
			end
			head_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
			s2_v    <= 1'b0;
		end else begin
			rf_q    <= rf_d;
			head_q  <= head_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			s2_v    <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2     <= res_d;
			ram_sel_s2 <= ram_sel_d;
		end
	end

	// merge the popped character once the RAM read has landed
	always_comb begin
		res = res_s2;
		if (ram_sel_s2) begin
			res.read_data = {24'd0, ram_rdata};
		end
	end

	assign res_push = s2_v;

endmodule

### hdl/uart_register_model.sv
`timescale 1ns / 1ps
// UART register window with receive queue.
//
// Input side is a queue: drive mode/offset/write_data/byte_mask/rx_char and
// raise push; the word is taken on a clock edge where push is high and full
// is low. Each word is a bus read, a masked bus write, a received character
// or an interrupt acknowledge.
// Result side is a queue too: while empty is low the oldest result sits on
// read_data/tx_valid/tx_char/raise_irq, and it is taken on an edge where pop
// is high. Every input word gives exactly one result, in order.
//
// Results pass the back end's result register into the result queue.
// Throughput: one word per cycle while the result queue has room; the back
// end executes one command a cycle and the receive RAM read is registered,
// so a queue read completes in the following stage.
// If the receiver stops popping, the result queue fills, the back end halts,
// the command queue fills and full rises; nothing is lost.
// Reset (arst_n low) loads the documented register reset values, empties
// both queues and the receive queue, and clears the pending interrupt flag.
module uart_register_model
	import umdl_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [11:0] offset,
	input  logic [31:0] write_data,
	input  logic [31:0] byte_mask,
	input  logic [7:0]  rx_char,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] read_data,
	output logic        tx_valid,
	output logic [7:0]  tx_char,
	output logic        raise_irq
);

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);

	cmd_t                          cmd_in;
	cmd_t                          cmd_head;
	logic                          cmd_empty;
	logic                          cmd_pop;
	logic [$clog2(CMDQ_DEPTH+1)-1:0] cmd_level;
	logic [$clog2(OUTQ_DEPTH+1)-1:0] oq_level;
	logic                          res_push;
	res_t                          res_in;
	res_t                          res_head;
	logic                          oq_full;

	umdl_front u_front (
		.mode       (mode),
		.offset     (offset),
		.write_data (write_data),
		.byte_mask  (byte_mask),
		.rx_char    (rx_char),
		.cmd        (cmd_in)
	);

	umdl_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty),
		.level  (cmd_level)
	);

	umdl_back #(
		.RX_DEPTH(RX_DEPTH),
		.OQ_DEPTH(OUTQ_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty | (cmd_level == '0)),
		.cmd_pop   (cmd_pop),
		.oq_level  (oq_level),
		.res_push  (res_push),
		.res       (res_in)
	);

	umdl_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push & ~oq_full),
		.wdata  (res_in),
		.full   (oq_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty),
		.level  (oq_level)
	);

	assign read_data = res_head.read_data;
	assign tx_valid  = res_head.tx_valid;
	assign tx_char   = res_head.tx_char;
	assign raise_irq = res_head.raise_irq;

endmodule
